// File: sv/stbs_pkg.sv
// shared types and constants for the sorted table binary search block
// no dependencies; imported by the controller, datapath and top level files of the block
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

  // default sizing, overridable on the top level
  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_ADDR_BITS   = 32;

  // fixed port field widths
  localparam int FIELD_W = 32;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;

  // item mode codes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_DELIVER
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_write;
    logic start;
    logic probe;
    logic compare;
    logic deliver;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_lookup;
    logic range_empty;
    logic hit;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: sv/stbs_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/stbs_ctrl.sv
// controller state machine for the sorted table binary search
// depends on stbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module stbs_ctrl
  import stbs_pkg::*;
(
  input  wire      clk,
  input  wire      rst,
  input  wire      in_valid,
  output logic     in_stall,
  input  status_t  status,
  output cmd_t     cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (status.is_lookup) begin
            cmd.start  = 1'b1;
            state_next = ST_PROBE;
          end else begin
            cmd.load_write = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (status.range_empty) begin
          state_next = ST_DELIVER;
        end else begin
          cmd.probe  = 1'b1;
          state_next = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        cmd.compare = 1'b1;
        if (status.hit) begin
          state_next = ST_DELIVER;
        end else begin
          state_next = ST_PROBE;
        end
      end
      ST_DELIVER: begin
        if (status.out_free) begin
          cmd.deliver = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/stbs_dpath.sv
// datapath: table memories, search bounds, key, result and output register
// depends on stbs_pkg and stbs_ram
`timescale 1ns / 1ps
`default_nettype none

module stbs_dpath
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int ADDR_BITS   = DEF_ADDR_BITS
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_write,
  input  wire [COUNT_W-1:0]  cfg_data,
  input  wire                mode,
  input  wire [INDEX_W-1:0]  entry_index,
  input  wire [FIELD_W-1:0]  entry_label,
  input  wire [FIELD_W-1:0]  entry_target,
  input  wire [FIELD_W-1:0]  search_key,
  output logic               out_valid,
  input  wire                out_stall,
  output logic               found,
  output logic [FIELD_W-1:0] match_target,
  input  cmd_t               cmd,
  output status_t            status
);

  localparam int STORE_W = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;

  logic [COUNT_W-1:0] entry_count;
  logic [CNT_W-1:0]   n_sat;
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   hi_x;
  logic [SUM_W-1:0]   mid_sum;
  logic [SUM_W-1:0]   mid_half;
  logic [IDX_W-1:0]   mid_c;
  logic [IDX_W-1:0]   mid_q;
  logic [STORE_W-1:0] key_q;
  logic [STORE_W-1:0] label_rdata;
  logic [STORE_W-1:0] target_rdata;
  logic               res_found;
  logic [FIELD_W-1:0] res_target;
  logic               index_ok;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic               key_less;
  logic               out_free;

  // entry count register; the user must write it only while idle, the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_write) begin
      entry_count <= cfg_data;
    end
  end

  // count clipped to the table depth
  always_comb begin
    if (32'(entry_count) > 32'(TABLE_DEPTH)) begin
      n_sat = CNT_W'(TABLE_DEPTH);
    end else begin
      n_sat = CNT_W'(entry_count);
    end
  end

  // load path, slots beyond the depth are dropped
  assign index_ok = 32'(entry_index) < 32'(TABLE_DEPTH);
  assign wr_en    = cmd.load_write && index_ok;
  assign wr_addr  = IDX_W'(entry_index);

  // probe position is the lower middle of [lo, hi_x)
  assign mid_sum  = SUM_W'(lo) + SUM_W'(hi_x) - SUM_W'(1);
  assign mid_half = mid_sum >> 1;
  assign mid_c    = mid_half[IDX_W-1:0];

  stbs_ram #(
    .WIDTH (STORE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_label_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (entry_label[STORE_W-1:0]),
    .raddr (mid_c),
    .rdata (label_rdata)
  );

  stbs_ram #(
    .WIDTH (STORE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_target_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (entry_target[STORE_W-1:0]),
    .raddr (mid_c),
    .rdata (target_rdata)
  );

  assign key_less = key_q < label_rdata;

  // search bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      lo   <= '0;
      hi_x <= '0;
    end else if (cmd.start) begin
      lo   <= '0;
      hi_x <= n_sat;
    end else if (cmd.compare) begin
      if (key_less) begin
        hi_x <= CNT_W'(mid_q);
      end else begin
        lo <= CNT_W'(mid_q) + CNT_W'(1);
      end
    end
  end

  // key, probe index and pending result
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_q      <= search_key[STORE_W-1:0];
      res_found  <= 1'b0;
      res_target <= '0;
    end else if (cmd.compare && (label_rdata == key_q)) begin
      res_found  <= 1'b1;
      res_target <= FIELD_W'(target_rdata);
    end
    if (cmd.probe) begin
      mid_q <= mid_c;
    end
  end

  // output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      found        <= res_found;
      match_target <= res_target;
    end
  end

  // status back to the controller
  always_comb begin
    status             = '0;
    status.is_lookup   = (mode == MODE_LOOKUP);
    status.range_empty = !(lo < hi_x);
    status.hit         = (label_rdata == key_q);
    status.out_free    = out_free;
  end

  // search range never inverts and stays within the table
  a_range_ordered: assert property (@(posedge clk) disable iff (rst)
    (lo <= hi_x) && (32'(hi_x) <= 32'(TABLE_DEPTH)))
    else $error("search range out of order");

  // a compare always follows a probe that fetched its entry
  a_compare_after_probe: assert property (@(posedge clk) disable iff (rst)
    cmd.compare |-> $past(cmd.probe))
    else $error("compare without preceding probe");

  // a result is never loaded over one still stalled
  a_deliver_free: assert property (@(posedge clk) disable iff (rst)
    cmd.deliver |-> out_free)
    else $error("result overwrites a stalled item");

  // an output item appears only from a deliver command
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.deliver))
    else $error("output valid without deliver");

endmodule

`default_nettype wire

// File: sv/sorted_table_binary_search.sv
// sorted label/target table with binary-search lookup
// load item: written when accepted, no result; lookup: accepted, then per probe a read
// and a compare, one more probe step on a miss to see the empty range, then a deliver
// step into the output register, held while the output is stalled, and no new item is
// taken until then; up to floor(log2(count))+1 probes; reset clears the controller,
// output valid and entry_count; table contents are undefined until loaded, not cleared
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int ADDR_BITS   = DEF_ADDR_BITS
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_write,
  input  wire [COUNT_W-1:0]  cfg_data,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire                mode,
  input  wire [INDEX_W-1:0]  entry_index,
  input  wire [FIELD_W-1:0]  entry_label,
  input  wire [FIELD_W-1:0]  entry_target,
  input  wire [FIELD_W-1:0]  search_key,
  output logic               out_valid,
  input  wire                out_stall,
  output logic               found,
  output logic [FIELD_W-1:0] match_target
);

  cmd_t    cmd;
  status_t status;

  // sequencing of loads and search probes
  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // table storage and search arithmetic
  stbs_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .entry_index  (entry_index),
    .entry_label  (entry_label),
    .entry_target (entry_target),
    .search_key   (search_key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .match_target (match_target),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

`default_nettype wire
